@@ sv/vlbp_pkg.sv @@
// Shared types, command codes and helper functions for the variable-length bit packer.
package vlbp_pkg;

  // Command codes carried on the input tuser.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_CLOSE  = 1'b1;

  // Word geometry.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned TOTAL_W = 48;

  // Field length that fills a whole word.
  localparam logic [LEN_W-1:0] LEN_FULL = 7'd64;

  // Terminator: four ones, 128 ones and a zero bit.
  localparam logic [7:0] TERM_BITS = 8'd133;

  // Pending fill at which the terminator ends exactly on a word boundary.
  localparam logic [FILL_W-1:0] FILL_EXACT = 6'd59;

  // Bits the terminator adds to the pending fill, modulo the word size.
  localparam logic [FILL_W-1:0] TERM_TAIL = 6'd5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One result word with its side fields.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  valid_bits;
    logic              last;
    logic              rejected;
  } beat_t;

  // Control summary of the item held in the input register.
  typedef struct packed {
    logic       has_beat;   // the item still has a word to send
    logic       beat_last;  // the current word is the item's final one
    logic       is_append;  // append that changes the state
    logic       is_close;   // close of an open stream
    logic [7:0] add_bits;   // bits this item adds to the running total
  } ctl_t;

  // Mask of the n lowest bits of a word.
  function automatic logic [WORD_W-1:0] low_mask(input logic [FILL_W-1:0] n);
    low_mask = ~({WORD_W{1'b1}} << n);
  endfunction

endpackage

@@ sv/vlbp_beat.sv @@
// Shift-merge and terminator word generation for one held item.
module vlbp_beat
  import vlbp_pkg::*;
(
  input  logic [WORD_W-1:0] acc,
  input  logic [FILL_W-1:0] fill,
  input  logic              closed,
  input  logic              cmd,
  input  logic [WORD_W-1:0] bits,
  input  logic [LEN_W-1:0]  len,
  input  logic [1:0]        beat_idx,
  output beat_t             beat,
  output ctl_t              ctl,
  output logic [WORD_W-1:0] acc_nxt,
  output logic [FILL_W-1:0] fill_nxt
);

  logic [LEN_W-1:0]    len_eff;
  logic [WORD_W-1:0]   bits_m;
  logic [WORD_W-1:0]   bits_left;
  logic [2*WORD_W-1:0] app_wide;
  logic [2*WORD_W-1:0] cls_wide;
  logic [LEN_W-1:0]    fill_sum;
  logic                app_emit;
  logic                is_rej;
  logic                is_app;
  logic                is_cls;
  logic [FILL_W-1:0]   part_valid;
  logic [WORD_W-1:0]   part_word;
  logic                cls_long;
  logic                cls_last;

  // Length saturates at a full word; bits above the length are dropped.
  assign len_eff = (len > LEN_FULL) ? LEN_FULL : len;
  assign bits_m  = (len_eff == LEN_FULL) ? bits : (bits & low_mask(len_eff[FILL_W-1:0]));

  // Item classification.
  assign is_rej = closed;
  assign is_app = !closed && (cmd == CMD_APPEND) && (len_eff != '0);
  assign is_cls = !closed && (cmd == CMD_CLOSE);

  // Append: left-align the field behind the pending bits and take the top word.
  assign bits_left = bits_m << (LEN_FULL - len_eff);
  assign app_wide  = {acc, bits_left} >> fill;
  assign fill_sum  = {1'b0, fill} + len_eff;
  assign app_emit  = fill_sum[LEN_W-1];
  assign fill_nxt  = fill_sum[FILL_W-1:0];
  assign acc_nxt   = ((acc << len_eff) | bits_m) & low_mask(fill_nxt);

  // Close: pending bits followed by a run of ones, then the final zero bit.
  assign cls_wide   = {acc, {WORD_W{1'b1}}} >> fill;
  assign part_valid = fill + TERM_TAIL;
  assign part_word  = low_mask(part_valid - 6'd1) << 1;
  assign cls_long   = fill > FILL_EXACT;
  assign cls_last   = cls_long ? (beat_idx == 2'd3) : (beat_idx == 2'd2);

  // Word selection for the current beat.
  always_comb begin
    beat = '0;
    if (is_rej) begin
      beat.rejected = 1'b1;
    end else if (is_app) begin
      beat.word       = app_wide[WORD_W-1:0];
      beat.valid_bits = LEN_FULL;
    end else begin
      case (beat_idx)
        2'd0: begin
          beat.word       = cls_wide[WORD_W-1:0];
          beat.valid_bits = LEN_FULL;
        end
        2'd1: begin
          beat.word       = '1;
          beat.valid_bits = LEN_FULL;
        end
        2'd2: begin
          if (fill < FILL_EXACT) begin
            beat.word       = part_word;
            beat.valid_bits = {1'b0, part_valid};
            beat.last       = 1'b1;
          end else if (fill == FILL_EXACT) begin
            beat.word       = {{(WORD_W-1){1'b1}}, 1'b0};
            beat.valid_bits = LEN_FULL;
            beat.last       = 1'b1;
          end else begin
            beat.word       = '1;
            beat.valid_bits = LEN_FULL;
          end
        end
        default: begin
          beat.word       = part_word;
          beat.valid_bits = {1'b0, part_valid};
          beat.last       = 1'b1;
        end
      endcase
    end
  end

  // Control summary for the top level.
  always_comb begin
    ctl.has_beat  = is_rej || is_cls || (is_app && app_emit);
    ctl.beat_last = is_cls ? cls_last : 1'b1;
    ctl.is_append = is_app;
    ctl.is_close  = is_cls;
    ctl.add_bits  = is_cls ? TERM_BITS : {1'b0, len_eff};
  end

endmodule

@@ sv/variable_length_bit_packer.sv @@
// Top level of the MSB-first variable-length bit packer with stream ports.
//
//  channel | dir | tdata (low bit up)                          | tuser    | tlast
//  --------+-----+---------------------------------------------+----------+---------
//  in_     | in  | field_bits[63:0], field_length[70:64], pad  | command  | -
//  out_    | out | word[63:0], valid_bits[70:64],              | rejected | last
//          |     | total_bits[118:71], pad                     |          |
//
// An append passes through the input register and leaves at most one word.
// A close holds the input register until all three or four words of the
// terminator have left; every other command leaves at most one word.
// The input register holds one command and the output register one word, so a new
// command is taken each cycle while the output side keeps up and no close is sent.
// Reset (rst_n low, synchronous) empties both registers and clears the state.
// An output stall holds the output word and, once it is full, the input register.
module variable_length_bit_packer
  import vlbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // field_bits, field_length, zero pad
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // word, valid_bits, total_bits, zero pad
  output logic         out_tuser,  // rejected
  output logic         out_tlast   // last
);

  // Input register.
  logic               s1_valid_r;
  logic               s1_cmd_r;
  logic [WORD_W-1:0]  s1_bits_r;
  logic [LEN_W-1:0]   s1_len_r;
  logic [1:0]         beat_r;

  // Packer state.
  logic [WORD_W-1:0]  acc_r;
  logic [FILL_W-1:0]  fill_r;
  logic               closed_r;
  logic [TOTAL_W-1:0] total_r;

  // Output register.
  logic               out_valid_r;
  beat_t              out_beat_r;
  logic [TOTAL_W-1:0] out_total_r;

  beat_t              beat;
  ctl_t               ctl;
  logic [WORD_W-1:0]  acc_nxt;
  logic [FILL_W-1:0]  fill_nxt;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_nxt;
  logic               slot_free;
  logic               fire;
  logic               retire;

  vlbp_beat u_beat (
    .acc      (acc_r),
    .fill     (fill_r),
    .closed   (closed_r),
    .cmd      (s1_cmd_r),
    .bits     (s1_bits_r),
    .len      (s1_len_r),
    .beat_idx (beat_r),
    .beat     (beat),
    .ctl      (ctl),
    .acc_nxt  (acc_nxt),
    .fill_nxt (fill_nxt)
  );

  // Saturating running total after the held command.
  assign total_sum = {1'b0, total_r} + {{(TOTAL_W-7){1'b0}}, ctl.add_bits};
  assign total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  // Handshake between the input register and the output register.
  assign slot_free = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && ctl.has_beat && slot_free;
  assign retire    = s1_valid_r && (!ctl.has_beat || (fire && ctl.beat_last));
  assign in_tready = !s1_valid_r || retire;

  // Input register and beat counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      beat_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (retire) begin
        beat_r <= '0;
      end else if (fire) begin
        beat_r <= beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_bits_r <= in_tdata[WORD_W-1:0];
      s1_len_r  <= in_tdata[WORD_W+LEN_W-1:WORD_W];
    end
  end

  // Packer state advances when the held word is done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      fill_r   <= '0;
      closed_r <= 1'b0;
      total_r  <= '0;
    end else if (retire && ctl.is_append) begin
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end else if (retire && ctl.is_close) begin
      acc_r    <= '0;
      fill_r   <= '0;
      closed_r <= 1'b1;
      total_r  <= total_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_beat_r  <= beat;
      out_total_r <= beat.rejected ? total_r : total_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_total_r, out_beat_r.valid_bits, out_beat_r.word};
  assign out_tuser  = out_beat_r.rejected;
  assign out_tlast  = out_beat_r.last;

  // A closed stream has nothing pending.
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> (fill_r == '0) && (acc_r == '0))
    else $error("pending bits left after close");

  // Only a close of an open stream walks through several beats.
  a_beat_close: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != 2'd0) |-> s1_valid_r && (s1_cmd_r == CMD_CLOSE) && !closed_r)
    else $error("beat counter moved outside a close");

  // Finishing a close locks the stream.
  a_close_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && ctl.is_close) |=> closed_r)
    else $error("stream not closed after terminator");

  // A rejected word never ends a stream.
  a_rej_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tlast)
    else $error("rejected word marked last");

  // A short word only appears as the final word.
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser && (out_beat_r.valid_bits != LEN_FULL)) |-> out_tlast)
    else $error("partial word not marked last");

endmodule

@@ tb/tb_variable_length_bit_packer.sv @@
// Self-checking testbench for the MSB-first variable-length bit packer.
module tb_variable_length_bit_packer
  import vlbp_pkg::*;
();

  // One input command as the driver sends it.
  typedef struct {
    logic        cmd;
    logic [63:0] bits;
    logic [6:0]  len;
  } field_cmd_t;

  // One output word with every field the block reports.
  typedef struct packed {
    logic [63:0] word;
    logic [6:0]  valid_bits;
    logic        last;
    logic        rejected;
    logic [47:0] total;
  } packed_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;   // field_bits, field_length, zero pad
  logic         in_tuser = 1'b0; // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;       // word, valid_bits, total_bits, zero pad
  logic         out_tuser;       // rejected
  logic         out_tlast;       // last

  // Commands waiting to be sent, and words the packer still owes.
  field_cmd_t   field_q[$];
  packed_word_t expected_words[$];
  packed_word_t cmd_words[$];

  // Shadow state of the packer.
  logic [63:0] acc_bits = '0;
  int unsigned acc_fill = 0;
  logic        closed = 1'b0;
  logic [47:0] bit_total = '0;

  // Generator side: pending fill as the stimulus will leave it.
  int unsigned gen_fill = 0;

  int unsigned errors = 0;
  int unsigned words_seen = 0;
  int unsigned accepted_count = 0;
  int unsigned cycle_count = 0;
  logic        hold_off = 1'b0;
  logic        steady;
  packed_word_t got, want;

  variable_length_bit_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A window of cycles in which neither side idles.
  always @(posedge clk) cycle_count <= cycle_count + 1;
  assign steady = (cycle_count >= 300) && (cycle_count < 600);

  // Shift one field into the shadow accumulator; a full word goes to cmd_words.
  task automatic pack_field(input logic [63:0] b, input int unsigned len);
    int unsigned  k, r;
    packed_word_t pw;
    if (len == 0) return;
    if (len > 64) len = 64;
    if (len < 64) b &= (64'd1 << len) - 64'd1;
    if (TOTAL_MAX - bit_total < len) bit_total = TOTAL_MAX;
    else bit_total = bit_total + len;
    if (acc_fill + len < 64) begin
      acc_bits = (acc_bits << len) | b;
      acc_fill = acc_fill + len;
    end else begin
      k = 64 - acc_fill;
      r = len - k;
      pw.word = (acc_fill == 0) ? 64'd0 : (acc_bits << k);
      pw.word |= b >> r;
      pw.valid_bits = 7'd64;
      pw.last = 1'b0;
      pw.rejected = 1'b0;
      pw.total = '0;
      cmd_words.insert(cmd_words.size(), pw);
      acc_bits = (r == 0) ? 64'd0 : (b & ((64'd1 << r) - 64'd1));
      acc_fill = r;
    end
  endtask

  // Work out every word one accepted command produces.
  task automatic pack_command(input logic cmd, input logic [63:0] bits, input logic [6:0] len);
    packed_word_t pw;
    cmd_words.delete();
    if (closed) begin
      pw = '0;
      pw.rejected = 1'b1;
      cmd_words.insert(cmd_words.size(), pw);
    end else if (cmd == CMD_APPEND) begin
      pack_field(bits, len);
    end else begin
      // Terminator: four ones, 128 ones, one zero.
      pack_field(64'hF, 4);
      pack_field('1, 64);
      pack_field('1, 64);
      pack_field(64'd0, 1);
      if (acc_fill != 0) begin
        pw.word = acc_bits;
        pw.valid_bits = acc_fill[6:0];
        pw.last = 1'b1;
        pw.rejected = 1'b0;
        pw.total = '0;
        cmd_words.insert(cmd_words.size(), pw);
      end else if (cmd_words.size() > 0) begin
        cmd_words[cmd_words.size()-1].last = 1'b1;
      end
      acc_bits = '0;
      acc_fill = 0;
      closed = 1'b1;
    end
    // Every word of the command carries the total after the whole command.
    foreach (cmd_words[i]) begin
      pw = cmd_words[i];
      pw.total = bit_total;
      expected_words.insert(expected_words.size(), pw);
    end
  endtask

  // Queue an append and track where it leaves the pending fill.
  task automatic queue_append(input logic [63:0] bits, input int unsigned len);
    field_cmd_t fc;
    fc.cmd = CMD_APPEND;
    fc.bits = bits;
    fc.len = len[6:0];
    field_q.insert(field_q.size(), fc);
    gen_fill = (gen_fill + len) % 64;
  endtask

  // Driver: offers queued commands, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pack_command(in_tuser, in_tdata[63:0], in_tdata[70:64]);
        accepted_count <= accepted_count + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (field_q.size() > 0 && (steady || $urandom_range(0, 99) >= 12)) begin
          in_tdata <= {1'b0, field_q[0].len, field_q[0].bits};
          in_tuser <= field_q[0].cmd;
          in_tvalid <= 1'b1;
          field_q.delete(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes words with random stalls and checks each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.word = out_tdata[63:0];
        got.valid_bits = out_tdata[70:64];
        got.total = out_tdata[118:71];
        got.last = out_tlast;
        got.rejected = out_tuser;
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("Unexpected word %0d: word=%h valid=%0d last=%b rej=%b total=%0d",
                     words_seen, got.word, got.valid_bits, got.last, got.rejected, got.total);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("Mismatch on word %0d:", words_seen);
              $display("  expected word=%h valid=%0d last=%b rej=%b total=%0d",
                       want.word, want.valid_bits, want.last, want.rejected, want.total);
              $display("  actual   word=%h valid=%0d last=%b rej=%b total=%0d",
                       got.word, got.valid_bits, got.last, got.rejected, got.total);
            end
          end
        end
      end
      out_tready <= !hold_off && (steady || $urandom_range(0, 99) >= 12);
    end
  end

  // Long receiver hold-off so the packer fills up and stalls its input.
  initial begin
    while (accepted_count < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus, reset and end of run.
  initial begin
    field_cmd_t  fc;
    int unsigned len, target;

    // Directed: length extremes, value extremes, masking of high bits.
    queue_append(64'd1, 1);
    queue_append(64'd0, 1);
    queue_append('1, 64);
    queue_append(64'd0, 64);
    queue_append(64'h8000_0000_0000_0001, 64);
    queue_append(64'hAAAA_AAAA_AAAA_AAAA, 64);
    queue_append(64'h5555_5555_5555_5555, 64);
    queue_append('1, 5);
    queue_append(64'hFFFF_FFFF_FFFF_FF80, 7);
    queue_append(64'h7FFF_FFFF_FFFF_FFFF, 63);
    queue_append({$urandom, $urandom}, 32);
    queue_append({$urandom, $urandom}, 17);
    queue_append({$urandom, $urandom}, 9);
    queue_append('1, 63);
    queue_append({$urandom, $urandom}, 2);
    queue_append({$urandom, $urandom}, 62);
    queue_append(64'hDEAD_BEEF_0000_0001, 33);
    queue_append({$urandom, $urandom}, 31);

    // Random appends, often short, with random bits above the length.
    repeat (430) begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 8);
      else len = $urandom_range(1, 64);
      queue_append({$urandom, $urandom}, len);
    end

    // Only one close of the open stream per reset: either land the terminator exactly on a word
    // boundary or leave a partial final word.
    if ($urandom_range(0, 1) == 1) target = FILL_EXACT;
    else begin
      target = $urandom_range(0, 62);
      if (target >= FILL_EXACT) target = target + 1;
    end
    len = (target + 64 - gen_fill) % 64;
    if (len == 0) len = 64;
    queue_append({$urandom, $urandom}, len);
    fc.cmd = CMD_CLOSE;
    fc.bits = {$urandom, $urandom};
    fc.len = $urandom_range(1, 64);
    field_q.insert(field_q.size(), fc);

    // Commands after the close must all come back rejected.
    repeat (10) begin
      fc.cmd = ($urandom_range(0, 3) == 0) ? CMD_CLOSE : CMD_APPEND;
      fc.bits = {$urandom, $urandom};
      fc.len = $urandom_range(1, 64);
      field_q.insert(field_q.size(), fc);
    end

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (field_q.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
